// ===== rtl/request_tag_tracker_with_timeout_defines.svh =====
// Assertion helpers used by the tracker top level
`ifndef REQUEST_TAG_TRACKER_WITH_TIMEOUT_DEFINES_SVH
`define REQUEST_TAG_TRACKER_WITH_TIMEOUT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtt_pkg.sv =====
package rtt_pkg;

    // time width of stored expiry values
    localparam int RTT_TIME_BITS   = 48;
    localparam int RTT_NUM_TAGS    = 256;
    localparam int RTT_SWEEP_LIMIT = 64;
    localparam int RTT_FOUND_W     = $clog2(RTT_SWEEP_LIMIT + 1);
    localparam logic [15:0] RTT_DFLT_TIMEOUT = 16'd6000;

    // operations
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_FREE = 3'd1;
    localparam logic [2:0] ST_NO_MATCH = 3'd2;
    localparam logic [2:0] ST_NOT_BUSY = 3'd3;
    localparam logic [2:0] ST_EXPIRED = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] now_ms;
        logic [7:0]  command;
        logic [15:0] req_timeout;
        logic [7:0]  inst_id;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] tag_out;
        logic [7:0] command_out;
        logic       last;
    } t_result;

    // classified item as queued between front and back
    typedef struct packed {
        logic [1:0]               op;
        logic [RTT_TIME_BITS-1:0] now;
        logic [RTT_TIME_BITS-1:0] expiry;
        logic [7:0]               cmd;
        logic [7:0]               id;
    } t_job;

endpackage

// ===== rtl/rtt_front.sv =====
module rtt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  rtt_pkg::t_item i_item,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    output logic           o_job_valid,
    output rtt_pkg::t_job  o_job,
    input  logic           i_job_pop
);
    import rtt_pkg::*;

    logic [15:0]              r_dflt;
    t_job                     r_q [2];
    logic                     r_wp;
    logic                     r_rp;
    logic [1:0]               r_cnt;
    logic                     push;
    logic                     pop;
    logic [15:0]              iv;
    logic [RTT_TIME_BITS-1:0] now_t;
    logic [RTT_TIME_BITS:0]   sum;
    t_job                     job;

    // default timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt <= RTT_DFLT_TIMEOUT;
        end else if (i_cfg_we) begin
            r_dflt <= i_cfg_data;
        end
    end

    // classify: mask time, saturating expiry
    always_comb begin
        now_t = RTT_TIME_BITS'(i_item.now_ms);
        iv = (i_item.req_timeout == 16'd0) ? r_dflt : i_item.req_timeout;
        sum = {1'b0, now_t} + (RTT_TIME_BITS + 1)'(iv);
        job.op = i_item.operation;
        job.now = now_t;
        job.expiry = sum[RTT_TIME_BITS] ? '1 : sum[RTT_TIME_BITS-1:0];
        job.cmd = i_item.command;
        job.id = i_item.inst_id;
    end

    assign o_busy = (r_cnt == 2'd2);
    assign push = i_start && !o_busy;
    assign pop = i_job_pop && (r_cnt != 2'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

endmodule

// ===== rtl/rtt_back.sv =====
module rtt_back #(
    parameter int NUM_TAGS = rtt_pkg::RTT_NUM_TAGS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  rtt_pkg::t_job    i_job,
    output logic             o_job_pop,
    output logic             o_strobe,
    output rtt_pkg::t_result o_result
);
    import rtt_pkg::*;

    localparam int TAG_W = $clog2(NUM_TAGS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_RESP   = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_SWDONE = 3'd4;

    logic [2:0]               r_state;
    logic [NUM_TAGS-1:0]      r_busy;
    logic [TAG_W-1:0]         r_ptr;
    t_job                     r_job;
    logic [TAG_W-1:0]         r_tag;
    logic [TAG_W-1:0]         r_cnt;
    logic                     r_hit;
    logic [TAG_W:0]           r_scan;
    logic                     r_chk_v;
    logic [TAG_W-1:0]         r_chk_tag;
    logic [RTT_FOUND_W-1:0]   r_found;
    logic                     r_pend_v;
    logic [TAG_W-1:0]         r_pend_tag;
    logic [7:0]               r_pend_cmd;
    logic                     r_out_v;
    t_result                  r_out;

    logic [7:0]               mem_cmd [NUM_TAGS];
    logic [RTT_TIME_BITS-1:0] mem_exp [NUM_TAGS];
    logic [7:0]               r_rd_cmd;
    logic [RTT_TIME_BITS-1:0] r_rd_exp;
    logic [TAG_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [TAG_W-1:0]         hd_idx;
    logic                     hd_in_range;
    logic                     expired;

    assign hd_idx = i_job.id[TAG_W-1:0];
    assign hd_in_range = ({1'b0, i_job.id} < 9'(NUM_TAGS));
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign rd_addr = (r_state == S_SWEEP) ? r_scan[TAG_W-1:0] : hd_idx;
    assign wr_en = (r_state == S_SEARCH) && !r_busy[r_tag];
    assign expired = r_chk_v && r_busy[r_chk_tag] && (r_rd_exp <= r_job.now);
    assign o_strobe = r_out_v;
    assign o_result = r_out;

    // entry store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_cmd[r_tag] <= r_job.cmd;
            mem_exp[r_tag] <= r_job.expiry;
        end
        r_rd_cmd <= mem_cmd[rd_addr];
        r_rd_exp <= mem_exp[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy <= '0;
            r_ptr <= '0;
            r_out_v <= 1'b0;
            r_chk_v <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_hit <= hd_in_range && r_busy[hd_idx];
                        unique case (i_job.op)
                            OP_REQUEST: begin
                                r_tag <= r_ptr;
                                r_cnt <= '0;
                                r_state <= S_SEARCH;
                            end
                            OP_RESPONSE: begin
                                r_state <= S_RESP;
                            end
                            OP_SWEEP: begin
                                r_scan <= '0;
                                r_chk_v <= 1'b0;
                                r_found <= '0;
                                r_pend_v <= 1'b0;
                                r_state <= S_SWEEP;
                            end
                            default: begin
                                // release completes here
                                r_out_v <= 1'b1;
                                r_out.tag_out <= i_job.id;
                                r_out.command_out <= 8'd0;
                                r_out.last <= 1'b1;
                                if (hd_in_range && r_busy[hd_idx]) begin
                                    r_busy[hd_idx] <= 1'b0;
                                    r_out.status <= ST_OK;
                                end else begin
                                    r_out.status <= ST_NOT_BUSY;
                                end
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    // one tag per cycle from the pointer
                    if (!r_busy[r_tag]) begin
                        r_busy[r_tag] <= 1'b1;
                        r_ptr <= (r_tag == TAG_W'(NUM_TAGS - 1)) ? '0 : r_tag + 1'b1;
                        r_out_v <= 1'b1;
                        r_out.status <= ST_OK;
                        r_out.tag_out <= 8'(r_tag);
                        r_out.command_out <= r_job.cmd;
                        r_out.last <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_cnt == TAG_W'(NUM_TAGS - 1)) begin
                        r_out_v <= 1'b1;
                        r_out.status <= ST_NO_FREE;
                        r_out.tag_out <= 8'd0;
                        r_out.command_out <= 8'd0;
                        r_out.last <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_tag <= (r_tag == TAG_W'(NUM_TAGS - 1)) ? '0 : r_tag + 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RESP: begin
                    // stored command is in the read register now
                    r_out_v <= 1'b1;
                    r_out.tag_out <= r_job.id;
                    r_out.last <= 1'b1;
                    if (r_hit && (r_rd_cmd == r_job.cmd)) begin
                        r_busy[r_job.id[TAG_W-1:0]] <= 1'b0;
                        r_out.status <= ST_OK;
                        r_out.command_out <= r_rd_cmd;
                    end else begin
                        r_out.status <= ST_NO_MATCH;
                        r_out.command_out <= 8'd0;
                    end
                    r_state <= S_IDLE;
                end
                S_SWEEP: begin
                    // read stage
                    if (r_scan < (TAG_W + 1)'(NUM_TAGS)) begin
                        r_scan <= r_scan + 1'b1;
                        r_chk_v <= 1'b1;
                        r_chk_tag <= r_scan[TAG_W-1:0];
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                    // check stage; one result held back to place the last flag
                    if (expired) begin
                        r_busy[r_chk_tag] <= 1'b0;
                        if (r_pend_v) begin
                            r_out_v <= 1'b1;
                            r_out.status <= ST_EXPIRED;
                            r_out.tag_out <= 8'(r_pend_tag);
                            r_out.command_out <= r_pend_cmd;
                            r_out.last <= 1'b0;
                        end
                        r_pend_v <= 1'b1;
                        r_pend_tag <= r_chk_tag;
                        r_pend_cmd <= r_rd_cmd;
                        r_found <= r_found + 1'b1;
                        if (r_found == RTT_FOUND_W'(RTT_SWEEP_LIMIT - 1)) begin
                            r_state <= S_SWDONE;
                        end
                    end else if (!r_chk_v && (r_scan == (TAG_W + 1)'(NUM_TAGS))) begin
                        r_state <= S_SWDONE;
                    end
                end
                S_SWDONE: begin
                    r_out_v <= 1'b1;
                    r_out.last <= 1'b1;
                    r_chk_v <= 1'b0;
                    if (r_pend_v) begin
                        r_out.status <= ST_EXPIRED;
                        r_out.tag_out <= 8'(r_pend_tag);
                        r_out.command_out <= r_pend_cmd;
                    end else begin
                        r_out.status <= ST_OK;
                        r_out.tag_out <= 8'd0;
                        r_out.command_out <= 8'd0;
                    end
                    r_pend_v <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/request_tag_tracker_with_timeout.sv =====
// Each accepted item passes the two-entry queue and then the back end. A request searches one
// tag per cycle from the round-robin pointer; a sweep makes one read a cycle.
// Throughput: the back end runs one item at a time; the two-entry queue takes items
// meanwhile. At most one result per cycle; no receiver stall.
// Reset (synchronous, i_rst_n low): all tags free, pointer zero, default timeout 6000,
// queue empty. The entry store has no reset; only values of busy entries are ever used.
module request_tag_tracker_with_timeout #(
    parameter int NUM_TAGS = rtt_pkg::RTT_NUM_TAGS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  rtt_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    output logic             o_strobe,
    output rtt_pkg::t_result o_result
);
    import rtt_pkg::*;
`include "request_tag_tracker_with_timeout_defines.svh"

    logic job_valid;
    t_job job;
    logic job_pop;

    rtt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    rtt_back #(
        .NUM_TAGS (NUM_TAGS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // only expiry reports may leave more results to follow
    `RTT_ASSERT_NOW(a_mid_is_expiry, o_strobe && !o_result.last, o_result.status == ST_EXPIRED, "non-final result is not an expiry")
    // a non-final expiry means the sweep still owns the back end
    `RTT_ASSERT_NOW(a_sweep_cont, o_strobe && !o_result.last, !job_pop, "queue popped mid-sweep")
    // no-free-tag carries zero fields
    `RTT_ASSERT_NOW(a_nofree_zero, o_strobe && (o_result.status == ST_NO_FREE), (o_result.tag_out == 8'd0) && (o_result.command_out == 8'd0), "no-free result has nonzero fields")

endmodule

// ===== sim/tb_request_tag_tracker_with_timeout.sv =====
module tb_request_tag_tracker_with_timeout;
    timeunit 1ns;
    timeprecision 1ps;
    import rtt_pkg::*;

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1500000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_item      i_item;
    logic       i_cfg_we;
    logic [15:0] i_cfg_data;
    logic       o_strobe;
    t_result    o_result;

    request_tag_tracker_with_timeout u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // tracker state mirror
    logic        tag_busy [RTT_NUM_TAGS];
    logic [7:0]  tag_cmd [RTT_NUM_TAGS];
    logic [47:0] tag_expiry [RTT_NUM_TAGS];
    logic [7:0]  next_tag;
    logic [15:0] dflt_timeout;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      mismatches;
    int      cycles;
    int      gap_left;
    logic    pause_req;
    logic    cfg_req;
    logic [15:0] cfg_value;
    logic [47:0] clock_ms;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // compute results for one accepted item and update the mirror
    task automatic track_item(input t_item it);
        t_result     r;
        logic [48:0] sum;
        logic [15:0] iv;
        int          t;
        int          n;
        r = '0;
        r.last = 1'b1;
        case (it.operation)
            OP_REQUEST: begin
                r.status = ST_NO_FREE;
                for (int i = 0; i < RTT_NUM_TAGS; i++) begin
                    t = (next_tag + i) % RTT_NUM_TAGS;
                    if (!tag_busy[t]) begin
                        iv = (it.req_timeout != 16'd0) ? it.req_timeout : dflt_timeout;
                        sum = {1'b0, it.now_ms} + iv;
                        tag_busy[t] = 1'b1;
                        tag_cmd[t] = it.command;
                        tag_expiry[t] = sum[48] ? TIME_MAX : sum[47:0];
                        next_tag = 8'(t + 1);
                        r.status = ST_OK;
                        r.tag_out = 8'(t);
                        r.command_out = it.command;
                        break;
                    end
                end
                expected_results.push_back(r);
            end
            OP_RESPONSE: begin
                r.tag_out = it.inst_id;
                if (tag_busy[it.inst_id] && tag_cmd[it.inst_id] == it.command) begin
                    tag_busy[it.inst_id] = 1'b0;
                    r.status = ST_OK;
                    r.command_out = tag_cmd[it.inst_id];
                end else begin
                    r.status = ST_NO_MATCH;
                end
                expected_results.push_back(r);
            end
            OP_RELEASE: begin
                r.tag_out = it.inst_id;
                r.status = tag_busy[it.inst_id] ? ST_OK : ST_NOT_BUSY;
                tag_busy[it.inst_id] = 1'b0;
                expected_results.push_back(r);
            end
            default: begin
                n = 0;
                for (int k = 0; k < RTT_NUM_TAGS && n < RTT_SWEEP_LIMIT; k++) begin
                    if (tag_busy[k] && tag_expiry[k] <= it.now_ms) begin
                        tag_busy[k] = 1'b0;
                        r.status = ST_EXPIRED;
                        r.tag_out = 8'(k);
                        r.command_out = tag_cmd[k];
                        r.last = 1'b0;
                        expected_results.push_back(r);
                        n++;
                    end
                end
                if (n == 0) begin
                    r = '0;
                    r.status = ST_OK;
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end else begin
                    expected_results[expected_results.size() - 1].last = 1'b1;
                end
            end
        endcase
    endtask

    // driver: start held while an item waits, config writes between phases
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_start && !o_busy) begin
                track_item(i_item);
            end
            if (i_start && o_busy) begin
                // hold the item
                i_cfg_we <= 1'b0;
            end else if (cfg_req && !i_start) begin
                i_cfg_we <= 1'b1;
                i_cfg_data <= cfg_value;
                dflt_timeout = cfg_value;
                cfg_req = 1'b0;
                i_start <= 1'b0;
            end else if (gap_left > 0) begin
                i_cfg_we <= 1'b0;
                gap_left <= gap_left - 1;
                i_start <= 1'b0;
            end else if (pending_items.size() != 0 && !pause_req && !cfg_req) begin
                i_cfg_we <= 1'b0;
                i_item <= pending_items.pop_front();
                i_start <= 1'b1;
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6));
            end else begin
                i_cfg_we <= 1'b0;
                i_start <= 1'b0;
            end
        end
    end

    // monitor: compare each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_result);
            end else begin
                t_result exp_r;
                exp_r = expected_results.pop_front();
                if (exp_r !== o_result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp_r, o_result);
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (cycles > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic t_item make_item(logic [1:0] op, logic [47:0] now_v, logic [7:0] cmd,
                                        logic [15:0] tmo, logic [7:0] id);
        t_item it;
        it.operation = op;
        it.now_ms = now_v;
        it.command = cmd;
        it.req_timeout = tmo;
        it.inst_id = id;
        return it;
    endfunction

    // wait until the block has drained everything queued so far
    task automatic drain();
        while (pending_items.size() != 0 || i_start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        drain();
        cfg_value = v;
        cfg_req = 1'b1;
        while (cfg_req) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // random request/response/release/sweep traffic on a rising clock
    task automatic random_burst(input int count);
        logic [7:0] id;
        int sel;
        for (int n = 0; n < count; n++) begin
            clock_ms = clock_ms + 48'($urandom_range(0, 400));
            sel = int'($urandom_range(0, 99));
            id = 8'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0) id = 8'($urandom);
            if (sel < 45)
                pending_items.push_back(make_item(OP_REQUEST, clock_ms,
                    8'($urandom_range(0, 3)),
                    ($urandom_range(0, 3) == 0) ? 16'd0 :
                    (($urandom_range(0, 9) == 0) ? 16'(16'hFFFF - $urandom_range(0, 3)) :
                    16'($urandom_range(1, 3000))), 8'($urandom)));
            else if (sel < 70)
                pending_items.push_back(make_item(OP_RESPONSE, clock_ms,
                    8'($urandom_range(0, 3)), 16'($urandom), id));
            else if (sel < 85)
                pending_items.push_back(make_item(OP_SWEEP, clock_ms, 8'($urandom),
                    16'($urandom), 8'($urandom)));
            else
                pending_items.push_back(make_item(OP_RELEASE, clock_ms, 8'($urandom),
                    16'($urandom), id));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        pause_req = 1'b0;
        cfg_req = 1'b0;
        cfg_value = '0;
        next_tag = '0;
        dflt_timeout = RTT_DFLT_TIMEOUT;
        clock_ms = 48'd1000;
        for (int k = 0; k < RTT_NUM_TAGS; k++) begin
            tag_busy[k] = 1'b0;
            tag_cmd[k] = '0;
            tag_expiry[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every op, misses, default timeout, saturation at the time limit
        pending_items.push_back(make_item(OP_SWEEP, 48'd0, 8'h00, 16'h0000, 8'h00));
        pending_items.push_back(make_item(OP_REQUEST, 48'd100, 8'hFF, 16'h0000, 8'hFF));
        pending_items.push_back(make_item(OP_REQUEST, 48'd100, 8'h00, 16'hFFFF, 8'h00));
        pending_items.push_back(make_item(OP_REQUEST, TIME_MAX - 10, 8'hA5, 16'd100, 8'h00));
        pending_items.push_back(make_item(OP_REQUEST, TIME_MAX, 8'h5A, 16'hFFFF, 8'h00));
        pending_items.push_back(make_item(OP_RESPONSE, 48'd200, 8'h01, 16'h0, 8'h00));
        pending_items.push_back(make_item(OP_RESPONSE, 48'd200, 8'hFF, 16'h0, 8'h00));
        pending_items.push_back(make_item(OP_RESPONSE, 48'd200, 8'hFF, 16'h0, 8'h00));
        pending_items.push_back(make_item(OP_RESPONSE, 48'd200, 8'h00, 16'h0, 8'hFF));
        pending_items.push_back(make_item(OP_RELEASE, 48'd200, 8'h00, 16'h0, 8'h01));
        pending_items.push_back(make_item(OP_RELEASE, 48'd200, 8'h00, 16'h0, 8'h01));
        pending_items.push_back(make_item(OP_RELEASE, 48'd200, 8'hFF, 16'hFFFF, 8'hFF));
        pending_items.push_back(make_item(OP_SWEEP, 48'd6099, 8'h00, 16'h0, 8'h00));
        pending_items.push_back(make_item(OP_SWEEP, TIME_MAX, 8'hFF, 16'hFFFF, 8'hFF));
        write_timeout(16'd0);

        // zero default: fill every tag, one more for no-free-tag
        for (int k = 0; k < RTT_NUM_TAGS + 1; k++)
            pending_items.push_back(make_item(OP_REQUEST, 48'd500, k[7:0], 16'd0, 8'h00));
        // hold the sender midway until everything sent has come back
        while (pending_items.size() > 128) @(posedge i_clk);
        pause_req = 1'b1;
        while (i_start || expected_results.size() != 0) @(posedge i_clk);
        pause_req = 1'b0;
        // all expire now: four split sweeps, then an empty one
        for (int k = 0; k < 5; k++)
            pending_items.push_back(make_item(OP_SWEEP, 48'd500, 8'h00, 16'h0, 8'h00));
        write_timeout(16'd1500);
        clock_ms = 48'd2000;
        random_burst(15);
        pending_items.push_back(make_item(OP_SWEEP, TIME_MAX, 8'h00, 16'h0, 8'h00));
        drain();
        if (expected_results.size() != 0)
            mismatches++;

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rtt_pkg.sv
rtl/rtt_front.sv
rtl/rtt_back.sv
rtl/request_tag_tracker_with_timeout.sv
sim/tb_request_tag_tracker_with_timeout.sv
